@@ design/etfs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the escape-time fractal sampler.
// No dependencies; used by escape_time_fractal_sampler.
package etfs_pkg;

    // Configuration registers arrive as Q4.28 words
    localparam int REG_BITS  = 32;
    localparam int REG_FRAC  = 28;
    localparam int LIMIT_BITS = 8;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd72;
    localparam int CFG_INDEX_BITS = 3;

    // Configuration register map
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ORIGIN_REAL     = 3'd0,
        CFG_ORIGIN_IMAG     = 3'd1,
        CFG_STEP_REAL       = 3'd2,
        CFG_STEP_IMAG       = 3'd3,
        CFG_JULIA_C_REAL    = 3'd4,
        CFG_JULIA_C_IMAG    = 3'd5,
        CFG_JULIA_MODE      = 3'd6,
        CFG_ITERATION_LIMIT = 3'd7
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_FX,
        ST_APPLY
    } state_t;

    // Which product the shared multiplier is working on
    typedef enum logic [2:0] {
        OP_PR,
        OP_PI,
        OP_RR,
        OP_II,
        OP_RI
    } op_t;

endpackage

@@ design/escape_time_fractal_sampler.sv @@
`timescale 1ns / 1ps
// Escape-time fractal sampler: maps a pixel to a complex point and iterates z = z^2 + c.
// Depends on etfs_pkg (state, operation and register-map types).
//
// Done pulses when z escapes or the iteration limit is reached after start is taken;
// with a zero limit done pulses on the next cycle.
// Throughput: one pixel at a time; busy stays high until the result is posted.
// Multiplies: LOAD, MUL_LO, MUL_HI, MUL_FX (z terms), APPLY; one half-width multiplier.
// Reset: async active low; config and control registers to defaults, datapath not reset.
// The result strobe cannot be stalled: escape_count is valid only while done is high.
module escape_time_fractal_sampler #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // pixel transaction
    input  logic                                start,
    output logic                                busy,
    input  logic [COORD_BITS-1:0]               pixel_x,
    input  logic [COORD_BITS-1:0]               pixel_y,
    // result transaction
    output logic                                done,
    output logic [COUNT_BITS-1:0]               escape_count,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [etfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [etfs_pkg::REG_BITS-1:0]       cfg_data
);

    localparam int W   = FRAC_BITS + 4;          // working word
    localparam int H   = (W + 1) / 2;            // low half of multiplier operand b
    localparam int PW  = W + H;                  // partial product width
    localparam int AW  = 2 * W;                  // full product width
    localparam int FXW = AW - FRAC_BITS;         // product after the fraction shift
    localparam int MW  = W + COORD_BITS + 1;     // pixel mapping sum width
    localparam int SH_UP = (FRAC_BITS >= etfs_pkg::REG_FRAC) ?
                           (FRAC_BITS - etfs_pkg::REG_FRAC) : 0;
    localparam int SH_DN = (FRAC_BITS < etfs_pkg::REG_FRAC) ?
                           (etfs_pkg::REG_FRAC - FRAC_BITS) : 0;

    localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W:0]   FOUR     = (W+1)'(1) << (FRAC_BITS + 2);

    // Q4.28 register to working format, truncating toward zero when narrowing
    function automatic logic signed [W-1:0] reg_to_word(input logic signed [31:0] r);
        logic signed [31:0] q;
        logic [31:0]        rem;
        logic signed [31:0] t;
        q   = r >>> SH_DN;
        rem = r & ((32'd1 << SH_DN) - 32'd1);
        t   = q + ((r[31] && (rem != 32'd0)) ? 32'sd1 : 32'sd0);
        return W'(t) <<< SH_UP;
    endfunction

    // Saturate a one-bit-grown sum to the working word
    function automatic logic signed [W-1:0] sat_add(input logic signed [W:0] v);
        if (v[W] != v[W-1])
            return v[W] ? WORD_MIN : WORD_MAX;
        return v[W-1:0];
    endfunction

    // Saturate a pixel mapping sum to the working word
    function automatic logic signed [W-1:0] sat_map(input logic signed [MW-1:0] v);
        if ((&v[MW-1:W-1]) || !(|v[MW-1:W-1]))
            return v[W-1:0];
        return v[MW-1] ? WORD_MIN : WORD_MAX;
    endfunction

    // Magnitude product to signed fixed-point word
    function automatic logic signed [W-1:0] fx_word(input logic [AW-1:0] acc,
                                                    input logic neg);
        logic [FXW-1:0] sh;
        logic [W-1:0]   mag;
        sh  = acc[AW-1:FRAC_BITS];
        mag = (|sh[FXW-1:W-1]) ? WORD_MAX : {1'b0, sh[W-2:0]};
        return neg ? $signed(-mag) : $signed(mag);
    endfunction

    function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] w);
        return w[W-1] ? -w : w;
    endfunction

    // Configuration registers
    logic signed [31:0] origin_real_reg, origin_imag_reg;
    logic signed [31:0] step_real_reg, step_imag_reg;
    logic signed [31:0] julia_c_real_reg, julia_c_imag_reg;
    logic               julia_mode_reg;
    logic [etfs_pkg::LIMIT_BITS-1:0] iteration_limit_reg;

    // Control
    etfs_pkg::state_t        state_reg, state_next;
    etfs_pkg::op_t           op_reg, op_next;
    logic                    init_reg, init_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    done_reg, done_next;

    // Datapath
    logic [COUNT_BITS-1:0]   escape_count_reg, escape_count_next;
    logic [COORD_BITS-1:0]   pixel_x_reg, pixel_x_next;
    logic [COORD_BITS-1:0]   pixel_y_reg, pixel_y_next;
    logic [W-1:0]            mul_a_reg, mul_a_next;
    logic [W-1:0]            mul_b_reg, mul_b_next;
    logic                    mul_neg_reg, mul_neg_next;
    logic [AW-1:0]           acc_reg, acc_next;
    logic signed [W-1:0]     fx_reg, fx_next;
    logic signed [W-1:0]     p_re_reg, p_re_next;
    logic signed [W-1:0]     zr_reg, zr_next;
    logic signed [W-1:0]     zi_reg, zi_next;
    logic signed [W-1:0]     cr_reg, cr_next;
    logic signed [W-1:0]     ci_reg, ci_next;
    logic signed [W-1:0]     rr_reg, rr_next;
    logic signed [W-1:0]     ii_reg, ii_next;

    // Combinational helpers
    logic [COUNT_BITS-1:0]   limit_w;
    logic [H-1:0]            mul_b_half;
    logic [PW-1:0]           mul_prod;
    logic signed [W-1:0]     step_word;
    logic signed [W-1:0]     origin_word;
    logic signed [MW-1:0]    origin_ext;
    logic signed [MW-1:0]    prod_ext;
    logic signed [MW-1:0]    map_sum;
    logic signed [W-1:0]     map_word;
    logic signed [W-1:0]     diff_sat;
    logic signed [W-1:0]     dbl_sat;
    logic signed [W-1:0]     new_re;
    logic signed [W-1:0]     new_im;
    logic [W:0]              mag_sq;
    logic                    escaped;

    assign busy         = (state_reg != etfs_pkg::ST_IDLE);
    assign done         = done_reg;
    assign escape_count = escape_count_reg;
    assign cfg_ready    = 1'b1;
    assign limit_w      = COUNT_BITS'(iteration_limit_reg);

    // Shared multiplier: one half of operand b per cycle
    assign mul_b_half = (state_reg == etfs_pkg::ST_MUL_HI) ?
                        H'(mul_b_reg[W-1:H]) : mul_b_reg[H-1:0];
    assign mul_prod   = mul_a_reg * mul_b_half;

    // Pixel mapping: origin plus signed pixel product, saturated
    assign origin_word = (op_reg == etfs_pkg::OP_PR) ? reg_to_word(origin_real_reg)
                                                     : reg_to_word(origin_imag_reg);
    assign origin_ext  = MW'(origin_word);
    assign prod_ext    = $signed({1'b0, acc_reg[W+COORD_BITS-1:0]});
    assign map_sum     = mul_neg_reg ? (origin_ext - prod_ext) : (origin_ext + prod_ext);
    assign map_word    = sat_map(map_sum);

    // z update from the squares and the cross product
    assign diff_sat = sat_add((W+1)'(rr_reg) - (W+1)'(ii_reg));
    assign new_re   = sat_add((W+1)'(diff_sat) + (W+1)'(cr_reg));
    assign dbl_sat  = sat_add({fx_reg, 1'b0});
    assign new_im   = sat_add((W+1)'(dbl_sat) + (W+1)'(ci_reg));

    // Escape test on the fresh squares (both non-negative)
    assign mag_sq  = {1'b0, rr_reg} + {1'b0, fx_reg};
    assign escaped = (mag_sq > FOUR);

    // Pick the step register for the mapping multiply
    assign step_word = (op_reg == etfs_pkg::OP_PR) ? reg_to_word(step_real_reg)
                                                   : reg_to_word(step_imag_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_real_reg     <= '0;
            origin_imag_reg     <= '0;
            step_real_reg       <= '0;
            step_imag_reg       <= '0;
            julia_c_real_reg    <= '0;
            julia_c_imag_reg    <= '0;
            julia_mode_reg      <= 1'b0;
            iteration_limit_reg <= etfs_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (etfs_pkg::cfg_index_t'(cfg_index))
                etfs_pkg::CFG_ORIGIN_REAL:     origin_real_reg     <= cfg_data;
                etfs_pkg::CFG_ORIGIN_IMAG:     origin_imag_reg     <= cfg_data;
                etfs_pkg::CFG_STEP_REAL:       step_real_reg       <= cfg_data;
                etfs_pkg::CFG_STEP_IMAG:       step_imag_reg       <= cfg_data;
                etfs_pkg::CFG_JULIA_C_REAL:    julia_c_real_reg    <= cfg_data;
                etfs_pkg::CFG_JULIA_C_IMAG:    julia_c_imag_reg    <= cfg_data;
                etfs_pkg::CFG_JULIA_MODE:      julia_mode_reg      <= cfg_data[0];
                etfs_pkg::CFG_ITERATION_LIMIT:
                    iteration_limit_reg <= cfg_data[etfs_pkg::LIMIT_BITS-1:0];
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= etfs_pkg::ST_IDLE;
            op_reg    <= etfs_pkg::OP_PR;
            init_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            init_reg  <= init_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        escape_count_reg <= escape_count_next;
        pixel_x_reg      <= pixel_x_next;
        pixel_y_reg      <= pixel_y_next;
        mul_a_reg        <= mul_a_next;
        mul_b_reg        <= mul_b_next;
        mul_neg_reg      <= mul_neg_next;
        acc_reg          <= acc_next;
        fx_reg           <= fx_next;
        p_re_reg         <= p_re_next;
        zr_reg           <= zr_next;
        zi_reg           <= zi_next;
        cr_reg           <= cr_next;
        ci_reg           <= ci_next;
        rr_reg           <= rr_next;
        ii_reg           <= ii_next;
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        init_next         = init_reg;
        count_next        = count_reg;
        done_next         = 1'b0;
        escape_count_next = escape_count_reg;
        pixel_x_next      = pixel_x_reg;
        pixel_y_next      = pixel_y_reg;
        mul_a_next        = mul_a_reg;
        mul_b_next        = mul_b_reg;
        mul_neg_next      = mul_neg_reg;
        acc_next          = acc_reg;
        fx_next           = fx_reg;
        p_re_next         = p_re_reg;
        zr_next           = zr_reg;
        zi_next           = zi_reg;
        cr_next           = cr_reg;
        ci_next           = ci_reg;
        rr_next           = rr_reg;
        ii_next           = ii_reg;

        unique case (state_reg)
            etfs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (limit_w == '0)
                    begin
                        // nothing to iterate: report zero right away
                        done_next         = 1'b1;
                        escape_count_next = '0;
                    end
                    else
                    begin
                        pixel_x_next = pixel_x;
                        pixel_y_next = pixel_y;
                        op_next      = etfs_pkg::OP_PR;
                        state_next   = etfs_pkg::ST_LOAD;
                    end
                end
            end

            // Latch multiplier operands as magnitudes plus a sign
            etfs_pkg::ST_LOAD:
            begin
                unique case (op_reg)
                    etfs_pkg::OP_PR:
                    begin
                        mul_a_next   = mag_of(step_word);
                        mul_b_next   = W'(pixel_x_reg);
                        mul_neg_next = step_word[W-1];
                    end
                    etfs_pkg::OP_PI:
                    begin
                        mul_a_next   = mag_of(step_word);
                        mul_b_next   = W'(pixel_y_reg);
                        mul_neg_next = step_word[W-1];
                    end
                    etfs_pkg::OP_RR:
                    begin
                        mul_a_next   = mag_of(zr_reg);
                        mul_b_next   = mag_of(zr_reg);
                        mul_neg_next = 1'b0;
                    end
                    etfs_pkg::OP_II:
                    begin
                        mul_a_next   = mag_of(zi_reg);
                        mul_b_next   = mag_of(zi_reg);
                        mul_neg_next = 1'b0;
                    end
                    etfs_pkg::OP_RI:
                    begin
                        mul_a_next   = mag_of(zr_reg);
                        mul_b_next   = mag_of(zi_reg);
                        mul_neg_next = zr_reg[W-1] ^ zi_reg[W-1];
                    end
                    default:
                    begin
                        mul_neg_next = 1'b0;
                    end
                endcase
                state_next = etfs_pkg::ST_MUL_LO;
            end

            etfs_pkg::ST_MUL_LO:
            begin
                acc_next   = AW'(mul_prod);
                state_next = etfs_pkg::ST_MUL_HI;
            end

            etfs_pkg::ST_MUL_HI:
            begin
                acc_next = acc_reg + (AW'(mul_prod) << H);
                if (op_reg == etfs_pkg::OP_PR || op_reg == etfs_pkg::OP_PI)
                    state_next = etfs_pkg::ST_APPLY;
                else
                    state_next = etfs_pkg::ST_MUL_FX;
            end

            // Scale product back to the working format
            etfs_pkg::ST_MUL_FX:
            begin
                fx_next    = fx_word(acc_reg, mul_neg_reg);
                state_next = etfs_pkg::ST_APPLY;
            end

            etfs_pkg::ST_APPLY:
            begin
                state_next = etfs_pkg::ST_LOAD;
                unique case (op_reg)
                    etfs_pkg::OP_PR:
                    begin
                        p_re_next = map_word;
                        op_next   = etfs_pkg::OP_PI;
                    end
                    etfs_pkg::OP_PI:
                    begin
                        // starting z and c by mode
                        if (julia_mode_reg)
                        begin
                            zr_next = p_re_reg;
                            zi_next = map_word;
                            cr_next = reg_to_word(julia_c_real_reg);
                            ci_next = reg_to_word(julia_c_imag_reg);
                        end
                        else
                        begin
                            zr_next = '0;
                            zi_next = '0;
                            cr_next = p_re_reg;
                            ci_next = map_word;
                        end
                        count_next = '0;
                        init_next  = 1'b1;
                        op_next    = etfs_pkg::OP_RR;
                    end
                    etfs_pkg::OP_RR:
                    begin
                        rr_next = fx_reg;
                        op_next = etfs_pkg::OP_II;
                    end
                    etfs_pkg::OP_II:
                    begin
                        ii_next = fx_reg;
                        op_next = etfs_pkg::OP_RI;
                        if (init_reg)
                        begin
                            // squares of the starting z: no escape test
                            init_next = 1'b0;
                        end
                        else if (escaped)
                        begin
                            escape_count_next = count_reg;
                            done_next         = 1'b1;
                            state_next        = etfs_pkg::ST_IDLE;
                        end
                        else if (count_reg + 1'b1 == limit_w)
                        begin
                            escape_count_next = limit_w;
                            done_next         = 1'b1;
                            state_next        = etfs_pkg::ST_IDLE;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    etfs_pkg::OP_RI:
                    begin
                        zr_next = new_re;
                        zi_next = new_im;
                        op_next = etfs_pkg::OP_RR;
                    end
                    default:
                    begin
                        state_next = etfs_pkg::ST_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = etfs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ bench/etfs_escape_checker.sv @@
`timescale 1ns / 1ps
// Escape-count checker: watches the pixel, result and configuration channels of the sampler.
// Predicts each escape count from its own register copy; depends on etfs_pkg.
module etfs_escape_checker
    import etfs_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [COORD_BITS-1:0]     pixel_x,
    input  logic [COORD_BITS-1:0]     pixel_y,
    input  logic                      done,
    input  logic [COUNT_BITS-1:0]     escape_count,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]       cfg_data,
    output int                        mismatches,
    output int                        outstanding,
    output int                        pixels_checked,
    output int                        escaped_early,
    output int                        reached_limit
);

    localparam int     WORD_BITS = FRAC_BITS + 4;
    localparam longint WORD_MAX  = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    localparam longint WORD_MIN  = -WORD_MAX - 1;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COUNT_BITS-1:0] count;
        bit                    escapes;
    } pixel_expect_t;

    // Register copy, updated on every configuration transaction
    logic [REG_BITS-1:0]   origin_re, origin_im, step_re, step_im, jc_re, jc_im;
    logic                  julia_on;
    logic [LIMIT_BITS-1:0] iter_limit;

    pixel_expect_t expected_counts[$];
    pixel_expect_t head, fresh;
    int            n_mismatch, n_checked, n_escaped, n_limit;

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    // Q4.28 register word to the working format
    function automatic longint q_from_reg(input logic [REG_BITS-1:0] r);
        longint v;
        v = longint'(signed'(r));
        if (FRAC_BITS >= REG_FRAC)
            return clamp_word(v <<< (FRAC_BITS - REG_FRAC));
        return v / (longint'(1) <<< (REG_FRAC - FRAC_BITS));
    endfunction

    // Sign-magnitude multiply: truncate toward zero, saturate the magnitude
    function automatic longint q_mul(input longint a, input longint b);
        bit           neg;
        logic [63:0]  ua, ub;
        logic [127:0] prod;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? -a : a;
        ub   = (b < 0) ? -b : b;
        prod = {64'd0, ua} * {64'd0, ub};
        prod = prod >> FRAC_BITS;
        if (prod > 128'(WORD_MAX))
            prod = 128'(WORD_MAX);
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    // Escape index of one pixel under the current register copy
    function automatic pixel_expect_t predict_escape(input logic [COORD_BITS-1:0] px,
                                                     input logic [COORD_BITS-1:0] py);
        pixel_expect_t e;
        longint        xl, yl, p_re, p_im, zr, zi, cr, ci, nr, ni, four;
        int            lim, idx, count;
        bit            hit;
        xl   = px;
        yl   = py;
        p_re = clamp_word(q_from_reg(origin_re) + xl * q_from_reg(step_re));
        p_im = clamp_word(q_from_reg(origin_im) + yl * q_from_reg(step_im));
        four = longint'(4) <<< FRAC_BITS;
        lim  = int'(iter_limit) & ((1 << COUNT_BITS) - 1);
        if (julia_on) begin
            zr = p_re;
            zi = p_im;
            cr = q_from_reg(jc_re);
            ci = q_from_reg(jc_im);
        end else begin
            zr = 0;
            zi = 0;
            cr = p_re;
            ci = p_im;
        end
        count = lim;
        hit   = 1'b0;
        idx   = 0;
        while (!hit && idx < lim) begin
            nr = clamp_word(clamp_word(q_mul(zr, zr) - q_mul(zi, zi)) + cr);
            ni = clamp_word(clamp_word(q_mul(zr, zi) * 2) + ci);
            zr = nr;
            zi = ni;
            if (q_mul(zr, zr) + q_mul(zi, zi) > four) begin
                count = idx;
                hit   = 1'b1;
            end
            idx++;
        end
        e.x       = px;
        e.y       = py;
        e.count   = count[COUNT_BITS-1:0];
        e.escapes = hit;
        return e;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            origin_re  = '0;
            origin_im  = '0;
            step_re    = '0;
            step_im    = '0;
            jc_re      = '0;
            jc_im      = '0;
            julia_on   = 1'b0;
            iter_limit = LIMIT_RESET;
            expected_counts.delete();
            n_mismatch = 0;
            n_checked  = 0;
            n_escaped  = 0;
            n_limit    = 0;
        end else begin
            // result transaction: compare with the oldest prediction
            if (done) begin
                if (expected_counts.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%t: escape_count %0d arrived with no pixel outstanding",
                                 $realtime, escape_count);
                end else begin
                    head = expected_counts.pop_front();
                    n_checked++;
                    if (escape_count !== head.count) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("%t: pixel (%0d,%0d) escape_count expected %0d, got %0d",
                                     $realtime, head.x, head.y, head.count, escape_count);
                    end
                end
            end

            // pixel transaction: predict with the registers as they stand
            if (start && !busy) begin
                fresh = predict_escape(pixel_x, pixel_y);
                if (fresh.escapes)
                    n_escaped++;
                else
                    n_limit++;
                expected_counts.push_back(fresh);
            end

            // configuration transaction
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ORIGIN_REAL:     origin_re  = cfg_data;
                    CFG_ORIGIN_IMAG:     origin_im  = cfg_data;
                    CFG_STEP_REAL:       step_re    = cfg_data;
                    CFG_STEP_IMAG:       step_im    = cfg_data;
                    CFG_JULIA_C_REAL:    jc_re      = cfg_data;
                    CFG_JULIA_C_IMAG:    jc_im      = cfg_data;
                    CFG_JULIA_MODE:      julia_on   = cfg_data[0];
                    CFG_ITERATION_LIMIT: iter_limit = cfg_data[LIMIT_BITS-1:0];
                    default: ;
                endcase
            end
        end

        mismatches     <= n_mismatch;
        outstanding    <= expected_counts.size();
        pixels_checked <= n_checked;
        escaped_early  <= n_escaped;
        reached_limit  <= n_limit;
    end

endmodule

@@ bench/tb_escape_time_fractal_sampler.sv @@
`timescale 1ns / 1ps
// Testbench top for escape_time_fractal_sampler: directed views, then random views and pixels.
// Depends on etfs_pkg, the sampler RTL and etfs_escape_checker, which does all prediction.
module tb_escape_time_fractal_sampler;
    import etfs_pkg::*;

    localparam int COORD_BITS  = 10;
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_BITS  = 8;
    localparam int ITEM_TARGET = 1550;
    // watchdog bound: above the slowest pixel at the deepest limit and the longest sender gap
    localparam int STALL_LIMIT = 20000;
    localparam logic [31:0] FIELD_STEP = 32'd786432;  // 3.0 / 1024 in Q4.28

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [COORD_BITS-1:0] pixel_x = '0;
    logic [COORD_BITS-1:0] pixel_y = '0;
    logic                  done;
    logic [COUNT_BITS-1:0] escape_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_ORIGIN_REAL;
    logic [REG_BITS-1:0]   cfg_data = '0;

    int mismatches, outstanding, pixels_checked, escaped_early, reached_limit;

    bit start_hi = 1'b0;
    int burst_left = 0;
    int pixels_sent = 0;
    int settings_count = 0;
    int julia_settings = 0;
    int quiet_cycles = 0;
    int n_items;

    escape_time_fractal_sampler #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) uut (.*);

    etfs_escape_checker #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) checker_i (.*);

    initial begin
        forever #2 clk = ~clk;
    end

    // Watchdog: any transaction on any channel restarts the count
    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("tb_escape_time_fractal_sampler: errors");
            $finish;
        end
    end

    function automatic logic [31:0] to_q(input real v);
        return int'(v * 268435456.0);
    endfunction

    // One register write; valid stays high for the next write
    task automatic put_reg(input cfg_index_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_view(input logic [31:0] o_re, input logic [31:0] o_im,
                                input logic [31:0] s_re, input logic [31:0] s_im,
                                input logic [31:0] c_re, input logic [31:0] c_im,
                                input logic [31:0] mode, input logic [31:0] lim);
        put_reg(CFG_ORIGIN_REAL, o_re);
        put_reg(CFG_ORIGIN_IMAG, o_im);
        put_reg(CFG_STEP_REAL, s_re);
        put_reg(CFG_STEP_IMAG, s_im);
        put_reg(CFG_JULIA_C_REAL, c_re);
        put_reg(CFG_JULIA_C_IMAG, c_im);
        put_reg(CFG_JULIA_MODE, mode);
        put_reg(CFG_ITERATION_LIMIT, lim);
        cfg_valid <= 1'b0;
        settings_count++;
        if (mode[0])
            julia_settings++;
    endtask

    // Pixel transaction; start stays high inside a burst, even while the block is busy
    task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
        int gap;
        start    <= 1'b1;
        start_hi  = 1'b1;
        pixel_x  <= x;
        pixel_y  <= y;
        do @(posedge clk); while (busy);
        pixels_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 7);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(20, 60);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap > 0) begin
                start   <= 1'b0;
                start_hi = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Wait until every predicted count has come back and the block is idle
    task automatic drain();
        if (start_hi) begin
            start   <= 1'b0;
            start_hi = 1'b0;
        end
        @(posedge clk);
        while (outstanding != 0 || busy) @(posedge clk);
    endtask

    // Either a sensible view near the set, or raw register noise
    task automatic random_view(output int items);
        int          st_re, st_im, ctr_re, ctr_im, c_re, c_im, lim;
        bit          julia;
        if ($urandom_range(0, 4) == 0) begin
            program_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, ($urandom & 32'hFFFF_FF00) | $urandom_range(0, 40));
            items = $urandom_range(10, 30);
        end else begin
            st_re = 1 + ($urandom_range(0, 786431) >> $urandom_range(0, 10));
            if ($urandom_range(0, 3) == 0)
                st_im = st_re;
            else
                st_im = 1 + ($urandom_range(0, 786431) >> $urandom_range(0, 10));
            if ($urandom_range(0, 7) == 0)
                st_re = -st_re;
            if ($urandom_range(0, 7) == 0)
                st_im = -st_im;
            c_re  = $urandom_range(0, 375809638) - 268435456;   // -1.0 .. 0.4
            c_im  = $urandom_range(0, 429496729) - 214748364;   // -0.8 .. 0.8
            julia = ($urandom_range(0, 2) == 0);
            if (julia) begin
                ctr_re = $urandom_range(0, 268435456) - 134217728;
                ctr_im = $urandom_range(0, 268435456) - 134217728;
            end else begin
                ctr_re = $urandom_range(0, 671088640) - 536870912;  // -2.0 .. 0.5
                ctr_im = $urandom_range(0, 644245094) - 322122547;  // -1.2 .. 1.2
            end
            // deep limits are slow, so those views get only a few pixels
            case ($urandom_range(0, 11))
                0: begin
                    lim   = $urandom_range(40, 255);
                    items = $urandom_range(3, 6);
                end
                1: begin
                    lim   = 0;
                    items = $urandom_range(5, 15);
                end
                default: begin
                    lim   = $urandom_range(1, 24);
                    items = $urandom_range(20, 80);
                end
            endcase
            program_view(ctr_re - 512 * st_re, ctr_im - 512 * st_im, st_re, st_im,
                         c_re, c_im, {31'd0, julia}, lim);
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: every point is the origin, never escapes
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        drain();

        // classic Mandelbrot field at the deepest limit; (0,512) sits exactly on |z|^2 = 4
        program_view(to_q(-2.0), to_q(-1.5), FIELD_STEP, FIELD_STEP, 0, 0, 0, 255);
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(683, 512);
        send_pixel(0, 512);
        send_pixel(1023, 0);
        send_pixel(512, 700);
        drain();

        // zero limit
        program_view(to_q(-2.0), to_q(-1.5), FIELD_STEP, FIELD_STEP, 0, 0, 0, 0);
        send_pixel(3, 9);
        send_pixel(1023, 0);
        drain();

        // saturation at the positive extreme
        program_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     0, 0, 0, 10);
        send_pixel(1023, 1023);
        send_pixel(0, 0);
        drain();

        // saturation at the negative extreme, Julia with extreme c
        program_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h8000_0000, 1, 10);
        send_pixel(1023, 1023);
        send_pixel(1, 1);
        drain();

        // Julia set around c = -0.8 + 0.156i
        program_view(to_q(-1.6), to_q(-1.0), to_q(3.2 / 1024.0), to_q(2.0 / 1024.0),
                     to_q(-0.8), to_q(0.156), 1, 40);
        send_pixel(512, 512);
        send_pixel(300, 700);
        send_pixel(0, 0);
        send_pixel(800, 200);
        drain();

        // random views, random pixels
        while (pixels_sent < ITEM_TARGET) begin
            random_view(n_items);
            repeat (n_items)
                send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
            drain();
        end

        // catch any stray result after the last expected one
        repeat (20) @(posedge clk);

        $display("Covered %0d pixels over %0d register settings (%0d in Julia mode).",
                 pixels_checked, settings_count, julia_settings);
        $display("Predicted %0d escapes before the limit and %0d pixels held to the limit.",
                 escaped_early, reached_limit);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_escape_time_fractal_sampler: clean");
        else
            $display("tb_escape_time_fractal_sampler: errors");
        $finish;
    end

endmodule
